// ===== src/tdss_pkg.sv =====
// Shared constants, codes and types for the time-of-day switch scheduler.
package tdss_pkg;

  localparam int SLOTS_DEFAULT = 5;
  localparam int SLOT_W        = 3;
  localparam int HOUR_W        = 5;
  localparam int MIN_W         = 6;
  localparam int SEC_W         = 6;
  localparam int TIME_W        = HOUR_W + MIN_W + SEC_W;

  localparam logic [HOUR_W-1:0] HOURS_PER_DAY      = HOUR_W'(24);
  localparam logic [MIN_W-1:0]  MINUTES_PER_HOUR   = MIN_W'(60);
  localparam logic [SEC_W-1:0]  SECONDS_PER_MINUTE = SEC_W'(60);

  localparam logic [2:0] ACT_TICK   = 3'd0;
  localparam logic [2:0] ACT_POWER  = 3'd1;
  localparam logic [2:0] ACT_START  = 3'd2;
  localparam logic [2:0] ACT_STOP   = 3'd3;
  localparam logic [2:0] ACT_REMOVE = 3'd4;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;

  // Write request into the slot tables.
  typedef struct packed {
    logic              wr_start;
    logic              wr_stop;
    logic              clr;
    logic [SLOT_W-1:0] idx;
    logic [TIME_W-1:0] tval;
  } tdss_wr_t;

endpackage

// ===== src/time_of_day_switch_scheduler.sv =====
// Top level of the time-of-day switch scheduler: sequencer, state and result register.
//
//   Channel | Dir | Handshake         | Payload
//   --------+-----+-------------------+----------------------------------------------
//   s       | in  | s_tvalid/s_tready | action, hour, minute, second, power_value, slot_index
//   m       | out | m_tvalid/m_tready | power_on, switched, status, active_slot
//
// A request passes through the execute and done steps before s_tready returns:
// most actions leave execute directly, while a tick while off tests the slots
// in turn through the single interval compare unit.
// rst is synchronous: tables empty, output off, no owning slot.
// The result sits in an output register; a stalled m side holds the sequencer
// in its final step, and a new request is taken while an old result waits.
module time_of_day_switch_scheduler import tdss_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [2:0] action, [7:3] hour, [13:8] minute, [19:14] second,
  // [20] power_value, [23:21] slot_index
  input  logic [23:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] power_on, [1] switched, [3:2] status, [6:4] active_slot, [7] zero
  output logic [7:0]  m_tdata
);

  localparam logic [SLOT_W-1:0] NO_SLOT   = SLOT_W'(SLOTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state;

  // Latched request.
  logic [2:0]        act;
  logic [TIME_W-1:0] tnow;
  logic              pval;
  logic [SLOT_W-1:0] sidx;

  // Switch state and per-request bookkeeping.
  logic              output_on;
  logic              was_on;
  logic [SLOT_W-1:0] owning_slot;
  logic [SLOT_W-1:0] scan;
  logic [1:0]        status;

  // Slot table access.
  tdss_wr_t          wr;
  logic [TIME_W-1:0] rd_start;
  logic [TIME_W-1:0] rd_stop;
  logic              rd_start_valid;
  logic              rd_stop_valid;
  logic [SLOTS-1:0]  start_valid;
  logic [SLOTS-1:0]  stop_valid;
  logic              in_range;

  logic              bad_time;
  logic [SLOTS-1:0]  sel_valid;
  logic              free_found;
  logic [SLOT_W-1:0] free_idx;
  logic              hit;

  tdss_slot_store #(.SLOTS(SLOTS)) u_store (
    .clk            (clk),
    .rst            (rst),
    .wr             (wr),
    .rd_idx         (scan),
    .rd_start       (rd_start),
    .rd_stop        (rd_stop),
    .rd_start_valid (rd_start_valid),
    .rd_stop_valid  (rd_stop_valid),
    .start_valid    (start_valid),
    .stop_valid     (stop_valid)
  );

  tdss_interval_cmp u_cmp (
    .start_t  (rd_start),
    .stop_t   (rd_stop),
    .now_t    (tnow),
    .in_range (in_range)
  );

  // Reject hours, minutes or seconds beyond a day's clock.
  assign bad_time = (tnow[TIME_W-1 -: HOUR_W] >= HOURS_PER_DAY) ||
                    (tnow[SEC_W +: MIN_W] >= MINUTES_PER_HOUR) ||
                    (tnow[SEC_W-1:0] >= SECONDS_PER_MINUTE);

  // Find the first free entry of the addressed table.
  assign sel_valid = (act == ACT_START) ? start_valid : stop_valid;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int j = SLOTS - 1; j >= 0; j--) begin
      if (!sel_valid[j]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(j);
      end
    end
  end

  assign hit = rd_start_valid && rd_stop_valid && in_range;

  // Table writes happen in the execute step of an add or remove.
  always_comb begin
    wr          = '0;
    wr.tval     = tnow;
    wr.idx      = free_idx;
    if (state == ST_EXEC) begin
      if (act == ACT_START && !bad_time && free_found) begin
        wr.wr_start = 1'b1;
      end
      if (act == ACT_STOP && !bad_time && free_found) begin
        wr.wr_stop = 1'b1;
      end
      if (act == ACT_REMOVE && sidx < NO_SLOT) begin
        wr.clr = 1'b1;
        wr.idx = sidx;
      end
    end
  end

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      output_on   <= 1'b0;
      owning_slot <= NO_SLOT;
      scan        <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      // Raise valid when a result lands, drop it once taken.
      if (state == ST_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            act    <= s_tdata[2:0];
            tnow   <= {s_tdata[7:3], s_tdata[13:8], s_tdata[19:14]};
            pval   <= s_tdata[20];
            sidx   <= s_tdata[23:21];
            was_on <= output_on;
            status <= STATUS_OK;
            // While on, the only slot worth testing is the owner.
            scan   <= output_on ? owning_slot : '0;
            state  <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          case (act)
            ACT_TICK: begin
              if (!output_on) begin
                if (hit) begin
                  output_on   <= 1'b1;
                  owning_slot <= scan;
                  state       <= ST_DONE;
                end else if (scan == LAST_SLOT) begin
                  state <= ST_DONE;
                end else begin
                  scan <= scan + SLOT_W'(1);
                end
              end else begin
                // Drop the on state once the owner's interval ends.
                if (owning_slot != NO_SLOT && !in_range) begin
                  output_on   <= 1'b0;
                  owning_slot <= NO_SLOT;
                end
                state <= ST_DONE;
              end
            end
            ACT_POWER: begin
              output_on   <= pval;
              owning_slot <= NO_SLOT;
              state       <= ST_DONE;
            end
            ACT_START, ACT_STOP: begin
              if (bad_time) begin
                status <= STATUS_INVALID;
              end else if (!free_found) begin
                status <= STATUS_FULL;
              end
              state <= ST_DONE;
            end
            default: begin
              state <= ST_DONE;
            end
          endcase
        end
        ST_DONE: begin
          // Hold until the output register is free.
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {1'b0, owning_slot, status, output_on != was_on, output_on};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/tdss_slot_store.sv =====
// Start and stop slot tables with their valid bits.
module tdss_slot_store import tdss_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  tdss_wr_t          wr,
  input  logic [SLOT_W-1:0] rd_idx,
  output logic [TIME_W-1:0] rd_start,
  output logic [TIME_W-1:0] rd_stop,
  output logic              rd_start_valid,
  output logic              rd_stop_valid,
  output logic [SLOTS-1:0]  start_valid,
  output logic [SLOTS-1:0]  stop_valid
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [TIME_W-1:0] start_tbl [SLOTS];
  logic [TIME_W-1:0] stop_tbl  [SLOTS];

  always_ff @(posedge clk) begin
    if (wr.wr_start) begin
      start_tbl[wr.idx[IDX_W-1:0]] <= wr.tval;
    end
    if (wr.wr_stop) begin
      stop_tbl[wr.idx[IDX_W-1:0]] <= wr.tval;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_valid <= '0;
      stop_valid  <= '0;
    end else begin
      if (wr.wr_start) begin
        start_valid[wr.idx[IDX_W-1:0]] <= 1'b1;
      end
      if (wr.wr_stop) begin
        stop_valid[wr.idx[IDX_W-1:0]] <= 1'b1;
      end
      if (wr.clr) begin
        start_valid[wr.idx[IDX_W-1:0]] <= 1'b0;
        stop_valid[wr.idx[IDX_W-1:0]]  <= 1'b0;
      end
    end
  end

  assign rd_start       = start_tbl[rd_idx[IDX_W-1:0]];
  assign rd_stop        = stop_tbl[rd_idx[IDX_W-1:0]];
  assign rd_start_valid = start_valid[rd_idx[IDX_W-1:0]];
  assign rd_stop_valid  = stop_valid[rd_idx[IDX_W-1:0]];

endmodule

// ===== src/tdss_interval_cmp.sv =====
// Shared interval test: is now strictly inside start..stop, wrapping past midnight.
module tdss_interval_cmp import tdss_pkg::*; (
  input  logic [TIME_W-1:0] start_t,
  input  logic [TIME_W-1:0] stop_t,
  input  logic [TIME_W-1:0] now_t,
  output logic              in_range
);

  logic start_lt_stop;
  logic after_start;
  logic before_stop;

  assign start_lt_stop = start_t < stop_t;
  assign after_start   = now_t > start_t;
  assign before_stop   = now_t < stop_t;

  // Plain interval needs both bounds; a wrapped one needs either.
  assign in_range = start_lt_stop ? (after_start && before_stop)
                                  : (after_start || before_stop);

endmodule

// ===== src/tdss_checker.sv =====
// Port-level checks for the time-of-day switch scheduler, bound to the top level.
module tdss_checker import tdss_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [23:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata
);

  localparam logic [SLOT_W-1:0] NO_SLOT = SLOT_W'(SLOTS);

  // A waiting result holds until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // s_tready is low in the cycle after a request is taken.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken back to back");

  // Status never carries the unused code.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[3:2] != 2'd3)
    else $error("bad status code");

  // Off means no owning slot.
  a_off_no_owner: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[6:4] == NO_SLOT)
    else $error("owner reported while off");

  // Owner never points past the table.
  a_owner_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[6:4] <= NO_SLOT)
    else $error("owner out of range");

endmodule

bind time_of_day_switch_scheduler tdss_checker #(.SLOTS(SLOTS)) u_tdss_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== sim/time_of_day_switch_scheduler_checker.sv =====
`timescale 1ns / 100ps
// Checker for the time-of-day switch scheduler: watches both channels and compares results.
module time_of_day_switch_scheduler_checker import tdss_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,
  output int          mismatches,
  output int          awaited
);

  typedef struct packed {
    logic              power_on;
    logic              switched;
    logic [1:0]        status;
    logic [SLOT_W-1:0] active_slot;
  } switch_result_t;

  // Shadow copy of the slot tables and the output state.
  logic [TIME_W-1:0] on_time  [SLOTS];
  logic [TIME_W-1:0] off_time [SLOTS];
  logic              on_set   [SLOTS];
  logic              off_set  [SLOTS];
  logic              power_state;
  logic [SLOT_W-1:0] owner;

  switch_result_t expected_results[$];

  initial mismatches = 0;
  initial awaited = 0;

  // Strict interval test; start not below stop wraps past midnight.
  function automatic logic in_window(input int j, input logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
    a = on_time[j];
    b = off_time[j];
    if (a < b) return (a < now) && (now < b);
    return (now > a) || (now < b);
  endfunction

  function automatic switch_result_t apply_request(input logic [23:0] word);
    logic [2:0]        act;
    logic [HOUR_W-1:0] hr;
    logic [MIN_W-1:0]  mn;
    logic [SEC_W-1:0]  sc;
    logic              pv;
    logic [2:0]        idx;
    logic [TIME_W-1:0] now;
    logic              was_on;
    logic [1:0]        st;
    logic              done;
    switch_result_t    r;
    act = word[2:0];
    hr  = word[7:3];
    mn  = word[13:8];
    sc  = word[19:14];
    pv  = word[20];
    idx = word[23:21];
    now = {hr, mn, sc};
    was_on = power_state;
    st = STATUS_OK;
    done = 1'b0;
    case (act)
      ACT_TICK: begin
        if (!power_state) begin
          for (int j = 0; j < SLOTS; j++) begin
            if (!done && on_set[j] && off_set[j] && in_window(j, now)) begin
              power_state = 1'b1;
              owner = SLOT_W'(j);
              done = 1'b1;
            end
          end
        end else if (owner < SLOTS) begin
          if (!in_window(owner, now)) begin
            power_state = 1'b0;
            owner = SLOT_W'(SLOTS);
          end
        end
      end
      ACT_POWER: begin
        power_state = pv;
        owner = SLOT_W'(SLOTS);
      end
      ACT_START, ACT_STOP: begin
        if (hr >= HOURS_PER_DAY || mn >= MINUTES_PER_HOUR || sc >= SECONDS_PER_MINUTE) begin
          st = STATUS_INVALID;
        end else begin
          st = STATUS_FULL;
          for (int j = 0; j < SLOTS; j++) begin
            if (!done) begin
              if (act == ACT_START && !on_set[j]) begin
                on_time[j] = now;
                on_set[j] = 1'b1;
                done = 1'b1;
              end else if (act == ACT_STOP && !off_set[j]) begin
                off_time[j] = now;
                off_set[j] = 1'b1;
                done = 1'b1;
              end
            end
          end
          if (done) st = STATUS_OK;
        end
      end
      ACT_REMOVE: begin
        // Stored times stay, so an owned on state still ends on schedule.
        if (idx < SLOTS) begin
          on_set[idx] = 1'b0;
          off_set[idx] = 1'b0;
        end
      end
      default: ;
    endcase
    r.power_on    = power_state;
    r.switched    = power_state != was_on;
    r.status      = st;
    r.active_slot = owner;
    return r;
  endfunction

  function automatic void note_failure(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endfunction

  always @(posedge clk) begin
    switch_result_t want;
    switch_result_t got;
    if (rst) begin
      for (int j = 0; j < SLOTS; j++) begin
        on_time[j]  = '0;
        off_time[j] = '0;
        on_set[j]   = 1'b0;
        off_set[j]  = 1'b0;
      end
      power_state = 1'b0;
      owner = SLOT_W'(SLOTS);
      expected_results.delete();
    end else begin
      // Check the result first: it can never belong to a request taken at this edge.
      if (m_tvalid && m_tready) begin
        got.power_on    = m_tdata[0];
        got.switched    = m_tdata[1];
        got.status      = m_tdata[3:2];
        got.active_slot = m_tdata[6:4];
        if (expected_results.size() == 0) begin
          note_failure($sformatf("unexpected result power_on=%0d switched=%0d status=%0d slot=%0d",
                                 got.power_on, got.switched, got.status, got.active_slot));
        end else begin
          want = expected_results.pop_front();
          if (got.power_on !== want.power_on || got.switched !== want.switched ||
              got.status !== want.status || got.active_slot !== want.active_slot)
            note_failure($sformatf(
              "power_on %0d/%0d switched %0d/%0d status %0d/%0d slot %0d/%0d (exp/act)",
              want.power_on, got.power_on, want.switched, got.switched,
              want.status, got.status, want.active_slot, got.active_slot));
        end
      end
      if (s_tvalid && s_tready) expected_results.push_back(apply_request(s_tdata));
    end
    awaited = expected_results.size();
  end

endmodule

// ===== sim/tb_time_of_day_switch_scheduler.sv =====
`timescale 1ns / 100ps
// Testbench top for the time-of-day switch scheduler: stimulus, pacing and verdict.
module tb_time_of_day_switch_scheduler import tdss_pkg::*;;

  localparam int SLOTS      = SLOTS_DEFAULT;
  localparam int STALL_LEN  = 300;   // long output hold-off, in cycles
  localparam int IDLE_LIMIT = 2000;  // watchdog: cycles without any handshake
  localparam int SETTLE     = 2 * (2 + SLOTS) + 6;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // [2:0] action, [7:3] hour, [13:8] minute, [19:14] second,
  // [20] power_value, [23:21] slot_index
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // [0] power_on, [1] switched, [3:2] status, [6:4] active_slot, [7] zero
  logic [7:0]  m_tdata;

  int   mismatches;
  int   awaited;
  int   quiet_cycles = 0;
  logic sender_gaps   = 1'b1;
  logic receiver_gaps = 1'b1;
  logic hold_output   = 1'b0;

  always #4 clk = ~clk;

  time_of_day_switch_scheduler #(.SLOTS(SLOTS)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  time_of_day_switch_scheduler_checker #(.SLOTS(SLOTS)) checker_i (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  // Watchdog: any handshake counts as progress.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("FAIL time_of_day_switch_scheduler");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: draw a stall per result, honor a long hold-off when asked.
  initial begin
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = receiver_gaps ? $urandom_range(0, 3) : 0;
      if (hold_output) begin
        m_tready <= 1'b0;
        repeat (STALL_LEN) @(negedge clk);
        hold_output = 1'b0;
      end else if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  function automatic logic [23:0] pack_request(input logic [2:0] act, input logic [4:0] hr,
                                               input logic [5:0] mn, input logic [5:0] sc,
                                               input logic pv, input logic [2:0] idx);
    return {idx, pv, sc, mn, hr, act};
  endfunction

  // Mostly a legal time of day; sometimes any bit pattern at all.
  function automatic logic [16:0] draw_clock();
    if ($urandom_range(0, 99) < 85)
      return {5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)), 6'($urandom_range(0, 59))};
    return 17'($urandom());
  endfunction

  function automatic logic [23:0] random_request();
    logic [23:0] w;
    int          pick;
    w = 24'($urandom());
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      w[2:0] = ACT_TICK;
      w[19:3] = draw_clock();
    end else if (pick < 48) begin
      w[2:0] = ACT_POWER;
    end else if (pick < 63) begin
      w[2:0] = ACT_START;
      w[19:3] = draw_clock();
    end else if (pick < 78) begin
      w[2:0] = ACT_STOP;
      w[19:3] = draw_clock();
    end else if (pick < 97) begin
      w[2:0] = ACT_REMOVE;
    end else begin
      w[2:0] = 3'($urandom_range(5, 7));  // unused actions
    end
    return w;
  endfunction

  // Offer one request and hold it until the block takes it.
  task automatic send_request(input logic [23:0] word);
    int gap;
    gap = sender_gaps ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= word;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Drop valid and wait for every outstanding result, then let the block settle.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (awaited != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty tables, rejected times, wrap past midnight, out-of-range ticks.
    send_request(pack_request(ACT_TICK, 5'd0, 6'd0, 6'd0, 1'b0, 3'd0));
    send_request(pack_request(ACT_START, 5'd24, 6'd0, 6'd0, 1'b0, 3'd0));
    send_request(pack_request(ACT_STOP, 5'd0, 6'd60, 6'd0, 1'b0, 3'd0));
    send_request(pack_request(ACT_START, 5'd0, 6'd0, 6'd60, 1'b0, 3'd0));
    send_request(pack_request(ACT_STOP, 5'd31, 6'd63, 6'd63, 1'b1, 3'd7));
    send_request(pack_request(ACT_START, 5'd23, 6'd59, 6'd59, 1'b0, 3'd0));
    send_request(pack_request(ACT_STOP, 5'd0, 6'd0, 6'd0, 1'b0, 3'd0));
    send_request(pack_request(ACT_TICK, 5'd31, 6'd63, 6'd63, 1'b0, 3'd0));
    send_request(pack_request(ACT_TICK, 5'd12, 6'd0, 6'd0, 1'b0, 3'd0));
    // Remove the owning slot mid-interval: its times still end the on state.
    send_request(pack_request(ACT_START, 5'd1, 6'd0, 6'd0, 1'b0, 3'd0));
    send_request(pack_request(ACT_STOP, 5'd2, 6'd0, 6'd0, 1'b0, 3'd0));
    send_request(pack_request(ACT_TICK, 5'd1, 6'd30, 6'd0, 1'b0, 3'd0));
    send_request(pack_request(ACT_REMOVE, 5'd0, 6'd0, 6'd0, 1'b0, 3'd1));
    send_request(pack_request(ACT_TICK, 5'd1, 6'd45, 6'd0, 1'b0, 3'd0));
    send_request(pack_request(ACT_TICK, 5'd3, 6'd0, 6'd0, 1'b0, 3'd0));
    // Start equal to stop reuses the freed slot.
    send_request(pack_request(ACT_START, 5'd5, 6'd0, 6'd0, 1'b0, 3'd0));
    send_request(pack_request(ACT_STOP, 5'd5, 6'd0, 6'd0, 1'b0, 3'd0));
    send_request(pack_request(ACT_TICK, 5'd5, 6'd0, 6'd0, 1'b0, 3'd0));
    send_request(pack_request(ACT_TICK, 5'd6, 6'd0, 6'd0, 1'b0, 3'd0));
    // Manual power overrides ownership; a tick never ends a manual ON.
    send_request(pack_request(ACT_POWER, 5'd0, 6'd0, 6'd0, 1'b1, 3'd0));
    send_request(pack_request(ACT_TICK, 5'd12, 6'd0, 6'd0, 1'b0, 3'd0));
    send_request(pack_request(ACT_POWER, 5'd0, 6'd0, 6'd0, 1'b0, 3'd0));
    send_request(pack_request(ACT_REMOVE, 5'd0, 6'd0, 6'd0, 1'b0, 3'd7));
    send_request(pack_request(3'd5, 5'd17, 6'd33, 6'd9, 1'b1, 3'd2));
    send_request(pack_request(3'd7, 5'd31, 6'd63, 6'd63, 1'b1, 3'd7));
    // Fill the start table until it reports full.
    for (int k = 0; k < 4; k++)
      send_request(pack_request(ACT_START, 5'(k + 8), 6'd0, 6'd0, 1'b0, 3'd0));
    wait_drained();

    // Random phases: both sides pacing, none, sender only, receiver only.
    for (int phase = 0; phase < 4; phase++) begin
      sender_gaps   = (phase == 0) || (phase == 2);
      receiver_gaps = (phase == 0) || (phase == 3);
      if (phase == 2) hold_output = 1'b1;  // sender keeps offering while results back up
      for (int n = 0; n < 400; n++) begin
        send_request(random_request());
        if (n == 200 && phase == 1) wait_drained();
      end
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("PASS time_of_day_switch_scheduler");
    end else begin
      $display("FAIL time_of_day_switch_scheduler");
    end
    $finish;
  end

endmodule
